FILE: rtl/ssp_pkg.sv
// Shared types, constants and helpers for the servo status packet checker.
// No dependencies; every other file in rtl/ except ssp_ram imports this package.
package ssp_pkg;

    // Payload buffer sizing
    localparam int MAX_PAYLOAD = 16;
    localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
    // Byte position in a frame runs up to MAX_PAYLOAD + 4
    localparam int CNT_W = $clog2(MAX_PAYLOAD + 5);

    localparam logic [7:0] SYNC_BYTE = 8'hFF;

    // Result status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_SHORT   = 2'd1;
    localparam logic [1:0] STATUS_BAD_HDR = 2'd2;
    localparam logic [1:0] STATUS_BAD_SUM = 2'd3;

    // Configuration register map
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_ID  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_LEN = 1'b1;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       window_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [1:0] status;
        logic       last;
    } t_out_item;

    // Frame close event from the byte checker to the readout
    typedef struct packed {
        logic       fire;    // a result is due
        logic       good;    // frame passed: stream the buffered payload
        logic [1:0] status;  // error code when not good
    } t_close_evt;

    typedef enum logic [1:0] {
        RD_IDLE,
        RD_ISSUE,
        RD_LOAD
    } t_rd_state;

    // Clamp the programmed payload length into 1..MAX_PAYLOAD
    function automatic logic [LEN_W-1:0] sat_len(input logic [4:0] v);
        int n;
        n = int'(v);
        if (n < 1) n = 1;
        if (n > MAX_PAYLOAD) n = MAX_PAYLOAD;
        return LEN_W'(n);
    endfunction

endpackage

FILE: rtl/servo_status_packet_checker.sv
// Top level of the servo status packet checker: config registers, byte
// checker, payload buffer RAM and result sequencer. Uses ssp_pkg.
//
//   Channel  Signals                          Direction  Content
//   in       i_in_valid/o_in_ready/i_in_data   sink       rx_byte, window_end
//   out      o_out_valid/i_out_ready/o_out_data source   payload_byte, status, last
//   cfg      i_cfg_we/i_cfg_idx/i_cfg_wdata   sink       expected_id, expected_len
//
// A received byte is checked as it is accepted; error results appear in the output
// register the cycle after the closing beat.
// A good frame streams its payload one byte at a time (buffer RAM read, then
// load into the output register); input is held off for that run.
// o_in_ready also drops while a result waits and the output is stalled.
// Reset is synchronous; the payload buffer needs no clearing pass.
module servo_status_packet_checker
    import ssp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    logic [7:0]       r_expected_id;
    logic [4:0]       r_expected_len;
    logic [LEN_W-1:0] len;

    logic             accept;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [7:0]       wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [7:0]       rd_data;
    t_close_evt       evt;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_id  <= 8'd1;
            r_expected_len <= 5'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_EXPECTED_ID:  r_expected_id  <= i_cfg_wdata;
                CFG_EXPECTED_LEN: r_expected_len <= i_cfg_wdata[4:0];
                default:          r_expected_id  <= r_expected_id;
            endcase
        end
    end

    assign len    = sat_len(r_expected_len);
    assign accept = i_in_valid && o_in_ready;

    ssp_frame_check u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_item        (i_in_data),
        .i_expected_id (r_expected_id),
        .i_len         (len),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_evt         (evt)
    );

    ssp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_payload_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    ssp_readout u_readout (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt       (evt),
        .i_len       (len),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: rtl/ssp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package dependency.
module ssp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read; data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/ssp_frame_check.sv
// Per-byte frame checker: position counter, header flags, running sum,
// payload writes into the buffer RAM and the frame close event. Uses ssp_pkg.
module ssp_frame_check
    import ssp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  t_in_item         i_item,
    input  logic [7:0]       i_expected_id,
    input  logic [LEN_W-1:0] i_len,
    output logic             o_wr_en,
    output logic [IDX_W-1:0] o_wr_addr,
    output logic [7:0]       o_wr_data,
    output t_close_evt       o_evt
);

    logic [CNT_W-1:0] r_byte_count, n_byte_count;
    logic             r_header_bad, n_header_bad;
    logic [7:0]       r_running_sum, n_running_sum;
    logic             r_frame_done, n_frame_done;

    logic [CNT_W-1:0] payload_pos;
    logic             at_close;
    logic [7:0]       want_sum;
    logic [7:0]       want_len;

    assign payload_pos = r_byte_count - CNT_W'(4);
    assign at_close    = r_byte_count >= (CNT_W'(i_len) + CNT_W'(4));
    assign want_sum    = ~r_running_sum;
    assign want_len    = 8'(i_len) + 8'd1;

    // Advance the window state on each accepted beat
    always_comb begin
        n_byte_count  = r_byte_count;
        n_header_bad  = r_header_bad;
        n_running_sum = r_running_sum;
        n_frame_done  = r_frame_done;
        o_wr_en       = 1'b0;
        o_wr_addr     = payload_pos[IDX_W-1:0];
        o_wr_data     = i_item.rx_byte;
        o_evt         = '{fire: 1'b0, good: 1'b0, status: STATUS_OK};
        if (i_accept) begin
            priority if (i_item.window_end) begin
                // window over: report short frame unless already closed
                o_evt.fire    = !r_frame_done;
                o_evt.status  = STATUS_SHORT;
                n_byte_count  = '0;
                n_header_bad  = 1'b0;
                n_running_sum = '0;
                n_frame_done  = 1'b0;
            end else if (r_frame_done) begin
                // drop bytes after a completed frame
            end else if (at_close) begin
                n_frame_done = 1'b1;
                o_evt.fire   = 1'b1;
                priority if (r_header_bad) begin
                    o_evt.status = STATUS_BAD_HDR;
                end else if (i_item.rx_byte != want_sum) begin
                    o_evt.status = STATUS_BAD_SUM;
                end else begin
                    o_evt.good = 1'b1;
                end
            end else begin
                n_byte_count = r_byte_count + CNT_W'(1);
                priority if (r_byte_count < CNT_W'(2)) begin
                    if (i_item.rx_byte != SYNC_BYTE) n_header_bad = 1'b1;
                end else if (r_byte_count == CNT_W'(2)) begin
                    if (i_item.rx_byte != i_expected_id) n_header_bad = 1'b1;
                    n_running_sum = r_running_sum + i_item.rx_byte;
                end else if (r_byte_count == CNT_W'(3)) begin
                    if (i_item.rx_byte != want_len) n_header_bad = 1'b1;
                    n_running_sum = r_running_sum + i_item.rx_byte;
                end else begin
                    o_wr_en       = 1'b1;
                    n_running_sum = r_running_sum + i_item.rx_byte;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count  <= '0;
            r_header_bad  <= 1'b0;
            r_running_sum <= '0;
            r_frame_done  <= 1'b0;
        end else begin
            r_byte_count  <= n_byte_count;
            r_header_bad  <= n_header_bad;
            r_running_sum <= n_running_sum;
            r_frame_done  <= n_frame_done;
        end
    end

    // Position never runs past the checksum slot of the longest frame
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count <= CNT_W'(MAX_PAYLOAD + 4))
        else $error("frame byte count past checksum slot");

endmodule

FILE: rtl/ssp_readout.sv
// Result sequencer: output register, error results, and payload readout
// from the buffer RAM (issue read, then load beat). Uses ssp_pkg.
module ssp_readout
    import ssp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_close_evt       i_evt,
    input  logic [LEN_W-1:0] i_len,
    output logic             o_rd_en,
    output logic [IDX_W-1:0] o_rd_addr,
    input  logic [7:0]       i_rd_data,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_data
);

    t_rd_state        r_state, n_state;
    logic [IDX_W-1:0] r_idx;
    logic [LEN_W-1:0] r_len;
    logic             r_out_valid;
    t_out_item        r_out;

    logic out_free;
    logic load;
    logic idx_last;

    assign out_free = !r_out_valid || i_out_ready;
    assign idx_last = (LEN_W'(r_idx) + LEN_W'(1)) == r_len;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            RD_IDLE:  if (i_evt.fire && i_evt.good) n_state = RD_ISSUE;
            RD_ISSUE: n_state = RD_LOAD;
            RD_LOAD: begin
                if (out_free) n_state = idx_last ? RD_IDLE : RD_ISSUE;
            end
            default:  n_state = RD_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_rd_en    = 1'b0;
        load       = 1'b0;
        o_in_ready = 1'b0;
        unique case (r_state)
            RD_IDLE:  o_in_ready = out_free;
            RD_ISSUE: o_rd_en = 1'b1;
            RD_LOAD:  load = out_free;
            default:  o_in_ready = 1'b0;
        endcase
    end

    assign o_rd_addr = r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RD_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Track the readout index and latch the run length
    always_ff @(posedge i_clk) begin
        if (r_state == RD_IDLE && i_evt.fire && i_evt.good) begin
            r_idx <= '0;
            r_len <= i_len;
        end else if (load && !idx_last) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    // Output register: payload beat, error beat, or drain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load || (i_evt.fire && !i_evt.good)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= '{payload_byte: i_rd_data, status: STATUS_OK, last: idx_last};
        end else if (i_evt.fire && !i_evt.good) begin
            r_out <= '{payload_byte: 8'd0, status: i_evt.status, last: 1'b1};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A frame closes only while the sequencer is idle
    a_evt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_evt.fire |-> (r_state == RD_IDLE))
        else $error("frame close during payload readout");

    // Each read is followed by its load phase
    a_read_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rd_en |=> (r_state == RD_LOAD))
        else $error("buffer read not followed by load");

    // The final payload beat returns the sequencer to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && idx_last) |=> (r_state == RD_IDLE && r_out_valid && r_out.last))
        else $error("payload run did not end cleanly");

    // Error results are single beats marked last with a zero byte
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != STATUS_OK)
            |-> (r_out.last && r_out.payload_byte == 8'd0))
        else $error("error result not a single last beat");

endmodule

FILE: sim/ssp_result_checker.sv
// Result checker for the servo status packet checker: watches the byte, result
// and register channels, predicts each result and compares it. Uses ssp_pkg.
module ssp_result_checker
    import ssp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in_item              i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out_item             i_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow of the register file
    logic [7:0]       reply_id;
    logic [4:0]       reply_len_reg;

    // Shadow of the frame tracker
    logic [CNT_W-1:0] frame_pos;
    logic             hdr_fault;
    logic [7:0]       frame_sum;
    logic             frame_closed;
    logic [7:0]       payload_buf [MAX_PAYLOAD];

    t_out_item        results_due [$];
    t_out_item        want;

    function automatic t_out_item make_result(input logic [7:0] data,
                                              input logic [1:0] code,
                                              input logic       tail);
        t_out_item r;
        r.payload_byte = data;
        r.status       = code;
        r.last         = tail;
        return r;
    endfunction

    // Advance the frame tracker by one beat and queue whatever it closes
    task automatic absorb_beat(input t_in_item beat);
        int         n;
        int         i;
        int         k;
        logic [7:0] b;
        b = beat.rx_byte;
        n = int'(reply_len_reg);
        if (n < 1) n = 1;
        if (n > MAX_PAYLOAD) n = MAX_PAYLOAD;

        if (beat.window_end) begin
            if (!frame_closed) results_due.push_back(make_result(8'h00, STATUS_SHORT, 1'b1));
            frame_pos    = '0;
            hdr_fault    = 1'b0;
            frame_sum    = 8'h00;
            frame_closed = 1'b0;
        end else if (frame_closed) begin
            // drop bytes until the window ends
        end else if (int'(frame_pos) >= n + 4) begin
            frame_closed = 1'b1;
            if (hdr_fault) begin
                results_due.push_back(make_result(8'h00, STATUS_BAD_HDR, 1'b1));
            end else if (b != ~frame_sum) begin
                results_due.push_back(make_result(8'h00, STATUS_BAD_SUM, 1'b1));
            end else begin
                for (i = 0; i < n; i++)
                    results_due.push_back(make_result(payload_buf[i], STATUS_OK, i == n - 1));
            end
        end else begin
            case (int'(frame_pos))
                0, 1: begin
                    if (b != SYNC_BYTE) hdr_fault = 1'b1;
                end
                2: begin
                    if (b != reply_id) hdr_fault = 1'b1;
                    frame_sum = frame_sum + b;
                end
                3: begin
                    if (int'(b) != n + 1) hdr_fault = 1'b1;
                    frame_sum = frame_sum + b;
                end
                default: begin
                    k = int'(frame_pos) - 4;
                    if (k < MAX_PAYLOAD) payload_buf[k] = b;
                    frame_sum = frame_sum + b;
                end
            endcase
            frame_pos = frame_pos + 1'b1;
        end
    endtask

    // Sample all channels at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reply_id      = 8'd1;
            reply_len_reg = 5'd1;
            frame_pos     = '0;
            hdr_fault     = 1'b0;
            frame_sum     = 8'h00;
            frame_closed  = 1'b0;
            for (int j = 0; j < MAX_PAYLOAD; j++) payload_buf[j] = 8'h00;
            results_due.delete();
            o_fail_count  = 0;
        end else begin
            // Compare the result beat first: nothing may answer its own input edge
            if (i_out_valid && i_out_ready) begin
                if (results_due.size() == 0) begin
                    o_fail_count = o_fail_count + 1;
                    $display("%0t: unexpected result, got byte %02h status %0d last %0d",
                             $time, i_out_data.payload_byte, i_out_data.status,
                             i_out_data.last);
                end else begin
                    want = results_due.pop_front();
                    if (i_out_data != want) o_fail_count = o_fail_count + 1;
                    if (i_out_data.payload_byte != want.payload_byte)
                        $display("%0t: payload_byte expected %02h, actual %02h",
                                 $time, want.payload_byte, i_out_data.payload_byte);
                    if (i_out_data.status != want.status)
                        $display("%0t: status expected %0d, actual %0d",
                                 $time, want.status, i_out_data.status);
                    if (i_out_data.last != want.last)
                        $display("%0t: last expected %0d, actual %0d",
                                 $time, want.last, i_out_data.last);
                end
            end

            // Track register writes
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_EXPECTED_ID) reply_id = i_cfg_wdata;
                else if (i_cfg_idx == CFG_EXPECTED_LEN) reply_len_reg = i_cfg_wdata[4:0];
            end

            if (i_in_valid && i_in_ready) absorb_beat(i_in_data);
        end
        o_pending = results_due.size();
    end

endmodule

FILE: sim/testbench.sv
// Top of the servo status packet checker bench: clock, reset, byte stimulus,
// register writes and the verdict. Uses ssp_pkg and ssp_result_checker.
module testbench
    import ssp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {
        FR_GOOD,
        FR_BAD_SYNC,
        FR_BAD_ID,
        FR_BAD_LEN,
        FR_BAD_SUM,
        FR_TRUNC,
        FR_NOISE
    } t_frame_kind;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in_item              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    int                    fail_count;
    int                    pending;

    int                    snd_idle_pct  = 0;
    int                    rcv_stall_pct = 0;
    int                    phase_beats;
    int                    cur_id  = 1;
    int                    cur_len = 1;
    logic [7:0]            frame_bytes [$];

    servo_status_packet_checker u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    ssp_result_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Stall the result channel at random
    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= rcv_stall_pct);
    end

    // Hard stop
    initial begin
        #1000000;
        $display("Regression FAIL");
        $finish;
    end

    // Present one beat, with random idle cycles ahead of it, and hold it until taken
    task automatic send_beat(input logic [7:0] b, input logic wend);
        t_in_item beat;
        beat.rx_byte    = b;
        beat.window_end = wend;
        @(negedge clk);
        while ($urandom_range(99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_bytes();
        foreach (frame_bytes[i]) begin
            send_beat(frame_bytes[i], 1'b0);
            phase_beats++;
        end
    endtask

    // Hold the sender until every result is out, then let the block settle
    task automatic wait_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        int v;
        wait_drain();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_EXPECTED_ID) begin
            cur_id = int'(val);
        end else begin
            v = int'(val[4:0]);
            cur_len = (v < 1) ? 1 : ((v > MAX_PAYLOAD) ? MAX_PAYLOAD : v);
        end
    endtask

    // Build one frame for the current settings, damage it as asked, close the window
    task automatic send_frame(input t_frame_kind kind);
        logic [7:0] sum;
        int         k;
        int         cut;
        frame_bytes.delete();
        frame_bytes.push_back(SYNC_BYTE);
        frame_bytes.push_back(SYNC_BYTE);
        frame_bytes.push_back(8'(cur_id));
        frame_bytes.push_back(8'(cur_len + 1));
        for (k = 0; k < cur_len; k++) frame_bytes.push_back(8'($urandom_range(255)));
        sum = 8'h00;
        for (k = 2; k < frame_bytes.size(); k++) sum = sum + frame_bytes[k];
        frame_bytes.push_back(~sum);

        case (kind)
            FR_BAD_SYNC: begin
                k = $urandom_range(1);
                frame_bytes[k] = frame_bytes[k] ^ 8'($urandom_range(255, 1));
            end
            FR_BAD_ID:  frame_bytes[2] = frame_bytes[2] ^ 8'($urandom_range(255, 1));
            FR_BAD_LEN: frame_bytes[3] = frame_bytes[3] ^ 8'($urandom_range(255, 1));
            FR_BAD_SUM: begin
                k = frame_bytes.size() - 1;
                frame_bytes[k] = frame_bytes[k] ^ 8'($urandom_range(255, 1));
            end
            FR_TRUNC: begin
                cut = $urandom_range(frame_bytes.size() - 1);
                while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
            end
            FR_NOISE: begin
                frame_bytes.delete();
                repeat ($urandom_range(8, 1)) frame_bytes.push_back(8'($urandom_range(255)));
            end
            default: ;
        endcase
        send_bytes();

        // Stray bytes after a completed frame
        if (kind != FR_TRUNC && kind != FR_NOISE && $urandom_range(2) == 0)
            repeat ($urandom_range(3, 1)) send_beat(8'($urandom_range(255)), 1'b0);

        send_beat(8'($urandom_range(255)), 1'b1);
        phase_beats++;
    endtask

    initial begin
        int          ph;
        int          r;
        t_frame_kind kind;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: window end with nothing received
        send_beat(8'hA5, 1'b1);
        // Minimal good frame with a zero payload, a stray byte, then a quiet window end
        frame_bytes = {SYNC_BYTE, SYNC_BYTE, 8'h01, 8'h02, 8'h00, 8'hFC};
        send_bytes();
        send_beat(8'h55, 1'b0);
        send_beat(8'h00, 1'b1);
        // Checksum mismatch on an all-ones payload
        frame_bytes = {SYNC_BYTE, SYNC_BYTE, 8'h01, 8'h02, 8'hFF, 8'h00};
        send_bytes();
        send_beat(8'hFF, 1'b1);
        // Bad sync and bad checksum together: header fault wins
        frame_bytes = {8'h00, SYNC_BYTE, 8'h01, 8'h02, 8'hFF, 8'h00};
        send_bytes();
        send_beat(8'hFF, 1'b1);
        // Header fault cut short by the window end: short frame wins
        frame_bytes = {SYNC_BYTE, 8'h00};
        send_bytes();
        send_beat(8'h00, 1'b1);
        // Shrink the length mid-frame: the next byte closes the frame as its checksum
        write_reg(CFG_EXPECTED_LEN, 8'd3);
        frame_bytes = {SYNC_BYTE, SYNC_BYTE, 8'h01, 8'h04, 8'h11, 8'h22};
        send_bytes();
        write_reg(CFG_EXPECTED_LEN, 8'd1);
        send_beat(8'hC7, 1'b0);
        send_beat(8'h00, 1'b1);

        // Random frames across register settings and idle profiles
        for (ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_EXPECTED_ID, 8'd0);
                    write_reg(CFG_EXPECTED_LEN, 8'd1);
                end
                1: begin
                    write_reg(CFG_EXPECTED_ID, 8'd253);
                    write_reg(CFG_EXPECTED_LEN, 8'd16);
                end
                2: begin
                    write_reg(CFG_EXPECTED_ID, 8'd255);
                    write_reg(CFG_EXPECTED_LEN, 8'd0);
                end
                3: begin
                    write_reg(CFG_EXPECTED_ID, 8'($urandom_range(255)));
                    write_reg(CFG_EXPECTED_LEN, 8'hFF);
                end
                default: begin
                    write_reg(CFG_EXPECTED_ID, 8'($urandom_range(255)));
                    write_reg(CFG_EXPECTED_LEN,
                              {3'($urandom_range(7)), 5'($urandom_range(6, 2))});
                end
            endcase
            case (ph % 4)
                0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin snd_idle_pct = 86; rcv_stall_pct = 0;  end
                2: begin snd_idle_pct = 0;  rcv_stall_pct = 86; end
                default: begin snd_idle_pct = 8; rcv_stall_pct = 8; end
            endcase
            phase_beats = 0;
            while (phase_beats < 10) begin
                r = $urandom_range(99);
                if (r < 60) kind = FR_GOOD;
                else kind = t_frame_kind'(1 + $urandom_range(5));
                send_frame(kind);
            end
        end

        wait_drain();
        repeat (40) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
